### rtl/bale_pkg.sv
// ----------------------------------------------------------------------------
// bale_pkg
// Shared types and codes of the bounded array list engine: operation and
// status codes, field widths and the controller command group.
// ----------------------------------------------------------------------------
package bale_pkg;

	localparam int FUNC_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 4;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 4;
	localparam int LEN_W    = 5;

	typedef logic [FUNC_W-1:0]   func_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam func_t FUNC_APPEND = 3'd0;
	localparam func_t FUNC_FIND   = 3'd1;
	localparam func_t FUNC_REMOVE = 3'd2;
	localparam func_t FUNC_INSERT = 3'd3;
	localparam func_t FUNC_READ   = 3'd4;

	localparam status_t ST_DONE      = 2'd0;
	localparam status_t ST_FULL      = 2'd1;
	localparam status_t ST_NOT_FOUND = 2'd2;
	localparam status_t ST_RANGE     = 2'd3;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;   // capture the operands of an accepted item
		logic exec;   // run the operation, update the list, register the result
	} cmd_t;

endpackage

### rtl/bounded_array_list_engine_top.sv
// ----------------------------------------------------------------------------
// bounded_array_list_engine_top
// Bounded list of signed 32-bit entries with append, find, remove, sorted
// insert and read-at-index operations.
//
//   channel   signals                        transfer
//   input     start, func, value, index      start high while busy low
//   result    done, status, position,        done high, one cycle, no stall
//             entry, length
//
// An item runs in order: first its operands are captured, then the
// per-cell compare, priority encode and shift of the cell row run; the
// result appears on the cycle after, with done high for exactly that cycle.
// A new item can be taken in the same cycle as the previous result.
// Reset clears the entry count and the controller; cell contents are
// undefined until written. The receiver cannot stall.
// ----------------------------------------------------------------------------
module bounded_array_list_engine_top #(
	parameter int CAPACITY = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [bale_pkg::FUNC_W-1:0]         func,
	input  logic signed [bale_pkg::VALUE_W-1:0] value,
	input  logic [bale_pkg::INDEX_W-1:0]        index,
	output logic                                done,
	output logic [bale_pkg::STATUS_W-1:0]       status,
	output logic [bale_pkg::POS_W-1:0]          position,
	output logic signed [bale_pkg::VALUE_W-1:0] entry,
	output logic [bale_pkg::LEN_W-1:0]          length
);
	import bale_pkg::*;

	cmd_t cmd;

	bale_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	bale_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.func     (func),
		.value    (value),
		.index    (index),
		.status   (status),
		.position (position),
		.entry    (entry),
		.length   (length)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("item did not complete in one work cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_length_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(length) <= CAPACITY))
		else $error("length beyond capacity");

endmodule

### rtl/bale_ctrl.sv
// ----------------------------------------------------------------------------
// bale_ctrl
// Controller: accepts an item, runs it through the datapath in the next
// cycle and raises the result strobe after that.
// ----------------------------------------------------------------------------
module bale_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output bale_pkg::cmd_t cmd
);
	import bale_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic done_q;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.exec;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

### rtl/bale_dpath.sv
// ----------------------------------------------------------------------------
// bale_dpath
// Datapath: a row of list cells with per-cell compare and shift, the entry
// count, priority encoders for the first match and the insert slot, and the
// result registers.
// ----------------------------------------------------------------------------
module bale_dpath #(
	parameter int CAPACITY = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bale_pkg::cmd_t                         cmd,
	input  logic [bale_pkg::FUNC_W-1:0]            func,
	input  logic signed [bale_pkg::VALUE_W-1:0]    value,
	input  logic [bale_pkg::INDEX_W-1:0]           index,
	output logic [bale_pkg::STATUS_W-1:0]          status,
	output logic [bale_pkg::POS_W-1:0]             position,
	output logic signed [bale_pkg::VALUE_W-1:0]    entry,
	output logic [bale_pkg::LEN_W-1:0]             length
);
	import bale_pkg::*;

	localparam int HW = $clog2(CAPACITY + 1);

	// operands of the item at work
	func_t                      func_q;
	logic signed [VALUE_W-1:0]  value_q;
	logic [INDEX_W-1:0]         index_q;

	logic signed [VALUE_W-1:0]  cells_q [CAPACITY];
	logic signed [VALUE_W-1:0]  cells_d [CAPACITY];
	logic [HW-1:0]              held_q;

	logic [CAPACITY-1:0]        eq;
	logic [CAPACITY-1:0]        stop;
	logic                       hit;
	logic [HW-1:0]              match_pos;
	logic [HW-1:0]              ins_pos;
	logic                       full;
	logic                       rd_ok;
	logic signed [VALUE_W-1:0]  rd_data;

	status_t                    status_d;
	logic [HW-1:0]              pos_d;
	logic signed [VALUE_W-1:0]  entry_d;
	logic [HW-1:0]              held_d;
	logic [31:0]                pos_ext;
	logic [31:0]                held_ext;

	status_t                    status_q;
	logic [POS_W-1:0]           position_q;
	logic signed [VALUE_W-1:0]  entry_q;
	logic [LEN_W-1:0]           length_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			value_q <= value;
			index_q <= index;
		end
	end

	assign full  = (32'(held_q) >= CAPACITY);
	assign rd_ok = (32'(index_q) < 32'(held_q));

	// per-cell compares against the operand
	always_comb begin
		for (int j = 0; j < CAPACITY; j++) begin
			eq[j]   = (j < 32'(held_q)) && (cells_q[j] == value_q);
			stop[j] = (j < 32'(held_q)) && !(cells_q[j] > value_q);
		end
	end

	// lowest match wins; insert goes just above the highest entry not above value
	always_comb begin
		hit       = 1'b0;
		match_pos = '0;
		ins_pos   = '0;
		rd_data   = '0;
		for (int j = CAPACITY - 1; j >= 0; j--) begin
			if (eq[j]) begin
				hit       = 1'b1;
				match_pos = HW'(j);
			end
		end
		for (int j = 0; j < CAPACITY; j++) begin
			if (stop[j]) begin
				ins_pos = HW'(j + 1);
			end
			if (32'(index_q) == j) begin
				rd_data = rd_data | cells_q[j];
			end
		end
	end

	// next value of each cell
	for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
		logic signed [VALUE_W-1:0] below;
		logic signed [VALUE_W-1:0] above;

		if (j == 0) begin : g_first
			assign below = value_q;
		end else begin : g_mid
			assign below = cells_q[j-1];
		end
		if (j == CAPACITY - 1) begin : g_last
			assign above = cells_q[j];
		end else begin : g_rest
			assign above = cells_q[j+1];
		end

		always_comb begin
			cells_d[j] = cells_q[j];
			case (func_q)
				FUNC_APPEND: begin
					if (!full && HW'(j) == held_q) begin
						cells_d[j] = value_q;
					end
				end
				FUNC_REMOVE: begin
					if (hit && HW'(j) >= match_pos) begin
						cells_d[j] = above;
					end
				end
				FUNC_INSERT: begin
					if (!full) begin
						if (HW'(j) == ins_pos) begin
							cells_d[j] = value_q;
						end else if (HW'(j) > ins_pos) begin
							cells_d[j] = below;
						end
					end
				end
				default: begin
					cells_d[j] = cells_q[j];
				end
			endcase
		end

		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				cells_q[j] <= cells_d[j];
			end
		end
	end

	always_comb begin
		status_d = ST_DONE;
		pos_d    = '0;
		entry_d  = '0;
		held_d   = held_q;
		case (func_q)
			FUNC_APPEND: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					pos_d  = held_q;
					held_d = held_q + 1'b1;
				end
			end
			FUNC_FIND: begin
				if (hit) begin
					pos_d = match_pos;
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			FUNC_REMOVE: begin
				if (hit) begin
					pos_d  = match_pos;
					held_d = held_q - 1'b1;
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			FUNC_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					pos_d  = ins_pos;
					held_d = held_q + 1'b1;
				end
			end
			FUNC_READ: begin
				if (rd_ok) begin
					entry_d = rd_data;
				end else begin
					status_d = ST_RANGE;
				end
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	assign pos_ext  = 32'(pos_d);
	assign held_ext = 32'(held_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (cmd.exec) begin
			held_q <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q   <= status_d;
			position_q <= pos_ext[POS_W-1:0];
			entry_q    <= entry_d;
			length_q   <= held_ext[LEN_W-1:0];
		end
	end

	assign status   = status_q;
	assign position = position_q;
	assign entry    = entry_q;
	assign length   = length_q;

endmodule
